[src/isbh_pkg.sv]
// Shared types and constants for the I2C slave buffer handler.
// Holds bus status codes, field widths and the event record passed down the pipeline.
// No dependencies.
package isbh_pkg;

   localparam int STATUS_W    = 8;
   localparam int BYTE_W      = 8;
   localparam int IDX_W       = 3;
   localparam int STORE_DEPTH = 5;
   localparam int CSR_INDEX_W = 3;

   localparam logic [STATUS_W-1:0] STATUS_MASK   = 8'hFC;
   localparam logic [STATUS_W-1:0] ST_READ_ADDR  = 8'hA8;
   localparam logic [STATUS_W-1:0] ST_TX_ACK     = 8'hB8;
   localparam logic [STATUS_W-1:0] ST_WRITE_ADDR = 8'h60;
   localparam logic [STATUS_W-1:0] ST_DATA       = 8'h80;
   localparam logic [STATUS_W-1:0] ST_STOP       = 8'hA0;

   localparam logic [BYTE_W-1:0] PAD_BYTE = 8'hAA;

   typedef logic [STORE_DEPTH-1:0][BYTE_W-1:0] rx_bytes_type;

   typedef struct packed {
      logic             tx_valid;
      logic             tx_pad;
      logic             tx_known;
      logic             message_ready;
      logic [IDX_W-1:0] rx_count;
      rx_bytes_type     rx_bytes;
   } evt_type;

endpackage

[src/isbh_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module isbh_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 5,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[src/isbh_ctrl.sv]
// Event decoder and buffer state: send and receive indexes, receive phase, receive store.
// Depends on isbh_pkg.
module isbh_ctrl #(
   parameter int BUFFER_BYTES = 5
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic [isbh_pkg::STATUS_W-1:0] status,
   input  logic [isbh_pkg::BYTE_W-1:0]   bus_byte,
   output logic [isbh_pkg::IDX_W-1:0]    rd_index,
   output isbh_pkg::evt_type             evt
);
   import isbh_pkg::*;

   localparam int SADDR_W = (BUFFER_BYTES > 1) ? $clog2(BUFFER_BYTES) : 1;
   localparam logic [IDX_W-1:0] BUF_LIMIT = IDX_W'(BUFFER_BYTES);

   localparam logic [1:0] PHASE_IDLE = 2'd0;
   localparam logic [1:0] PHASE_ADDR = 2'd1;
   localparam logic [1:0] PHASE_DATA = 2'd2;

   logic [IDX_W-1:0]  send_index_ff, send_index_in;
   logic [IDX_W-1:0]  rx_index_ff, rx_index_in;
   logic [1:0]        phase_ff, phase_in;
   logic [BYTE_W-1:0] store_ff [BUFFER_BYTES];
   logic              store_wr;
   logic [STATUS_W-1:0] code;
   logic [IDX_W-1:0]  send_eff;
   rx_bytes_type      rx_masked;

   for (genvar k = 0; k < STORE_DEPTH; k++) begin : g_rx
      if (k < BUFFER_BYTES) begin : g_held
         assign rx_masked[k] = (IDX_W'(k) < rx_index_ff) ? store_ff[k] : '0;
      end else begin : g_none
         assign rx_masked[k] = '0;
      end
   end

   assign code = status & STATUS_MASK;

   always_comb begin
      send_index_in     = send_index_ff;
      rx_index_in       = rx_index_ff;
      phase_in          = phase_ff;
      store_wr          = 1'b0;
      rd_index          = '0;
      send_eff          = send_index_ff;
      evt               = '0;
      unique case (code)
         ST_READ_ADDR, ST_TX_ACK: begin
            // restart the transmit index on a fresh read address
            if (code == ST_READ_ADDR) begin
               send_eff = '0;
            end
            evt.tx_valid = 1'b1;
            if (send_eff < BUF_LIMIT) begin
               rd_index      = send_eff;
               send_index_in = send_eff + IDX_W'(1);
            end else begin
               evt.tx_pad    = 1'b1;
               send_index_in = send_eff;
            end
         end
         ST_WRITE_ADDR: begin
            phase_in    = PHASE_ADDR;
            rx_index_in = '0;
         end
         ST_DATA: begin
            if (phase_ff == PHASE_ADDR) begin
               phase_in = PHASE_DATA;
            end
            // drop bytes past the end of the buffer
            if (rx_index_ff < BUF_LIMIT) begin
               store_wr    = 1'b1;
               rx_index_in = rx_index_ff + IDX_W'(1);
            end
         end
         ST_STOP: begin
            if (phase_ff == PHASE_DATA) begin
               evt.message_ready = 1'b1;
               evt.rx_count      = rx_index_ff;
               evt.rx_bytes      = rx_masked;
               phase_in          = PHASE_IDLE;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         send_index_ff <= '0;
         rx_index_ff   <= '0;
         phase_ff      <= PHASE_IDLE;
      end else if (accept) begin
         send_index_ff <= send_index_in;
         rx_index_ff   <= rx_index_in;
         phase_ff      <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && store_wr) begin
         store_ff[rx_index_ff[SADDR_W-1:0]] <= bus_byte;
      end
   end

endmodule

[src/i2c_slave_buffer_handler.sv]
// I2C slave transmit/receive buffer handler: one bus status event in, one result out.
// Pipeline: an accepted request passes through stage 1 and then the output register to the result.
// Throughput: one request per cycle, unless stage 1 is full and rsp_stall holds the full output register.
// Reset clears indexes, receive phase and pipeline; transmit bytes read 0 until written.
// The register port is always ready.
// Depends on isbh_pkg, isbh_ctrl and isbh_ram.
module i2c_slave_buffer_handler #(
   parameter int BUFFER_BYTES = 5
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [isbh_pkg::STATUS_W-1:0]    req_status,
   input  logic [isbh_pkg::BYTE_W-1:0]      req_bus_byte,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic                             rsp_tx_valid,
   output logic [isbh_pkg::BYTE_W-1:0]      rsp_tx_byte,
   output logic                             rsp_message_ready,
   output logic [isbh_pkg::IDX_W-1:0]       rsp_rx_count,
   output logic [isbh_pkg::BYTE_W-1:0]      rsp_rx_byte_0,
   output logic [isbh_pkg::BYTE_W-1:0]      rsp_rx_byte_1,
   output logic [isbh_pkg::BYTE_W-1:0]      rsp_rx_byte_2,
   output logic [isbh_pkg::BYTE_W-1:0]      rsp_rx_byte_3,
   output logic [isbh_pkg::BYTE_W-1:0]      rsp_rx_byte_4,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [isbh_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [isbh_pkg::BYTE_W-1:0]      csr_data
);
   import isbh_pkg::*;

   localparam int ADDR_W = (BUFFER_BYTES > 1) ? $clog2(BUFFER_BYTES) : 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_LIMIT = CSR_INDEX_W'(BUFFER_BYTES);

   logic              req_accept;
   logic              out_take;
   logic              s1_move;
   logic [IDX_W-1:0]  rd_index;
   evt_type           s0_evt;
   logic [BYTE_W-1:0] ram_q;
   logic              csr_wr;

   logic                   s1_valid_ff, s1_valid_in;
   evt_type                s1_evt_ff, s1_evt_in;
   logic [BUFFER_BYTES-1:0] tx_written_ff;

   logic              out_valid_ff, out_valid_in;
   logic              out_tx_valid_ff, out_msg_ff;
   logic [BYTE_W-1:0] out_tx_byte_ff, out_tx_byte_in;
   logic [IDX_W-1:0]  out_count_ff;
   rx_bytes_type      out_rx_ff;

   // output register frees when empty or being taken; stage 1 holds otherwise
   assign out_take    = !out_valid_ff || !rsp_stall;
   assign s1_move     = s1_valid_ff && out_take;
   assign req_stall   = s1_valid_ff && !out_take;
   assign req_accept  = req_valid && !req_stall;
   assign s1_valid_in = req_accept || (s1_valid_ff && !out_take);
   assign out_valid_in = out_take ? s1_valid_ff : out_valid_ff;

   assign csr_ready = 1'b1;
   assign csr_wr    = csr_valid && (csr_index < CSR_LIMIT);

   isbh_ctrl #(
      .BUFFER_BYTES(BUFFER_BYTES)
   ) u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .accept  (req_accept),
      .status  (req_status),
      .bus_byte(req_bus_byte),
      .rd_index(rd_index),
      .evt     (s0_evt)
   );

   isbh_ram #(
      .WIDTH(BYTE_W),
      .DEPTH(BUFFER_BYTES)
   ) u_tx_ram (
      .clock  (clock),
      .wr_en  (csr_wr),
      .wr_addr(csr_index[ADDR_W-1:0]),
      .wr_data(csr_data),
      .rd_en  (req_accept),
      .rd_addr(rd_index[ADDR_W-1:0]),
      .rd_data(ram_q)
   );

   always_comb begin
      s1_evt_in          = s0_evt;
      s1_evt_in.tx_known = tx_written_ff[rd_index[ADDR_W-1:0]];
   end

   always_comb begin
      out_tx_byte_in = '0;
      if (s1_evt_ff.tx_valid) begin
         if (s1_evt_ff.tx_pad) begin
            out_tx_byte_in = PAD_BYTE;
         end else if (s1_evt_ff.tx_known) begin
            out_tx_byte_in = ram_q;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         tx_written_ff <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         if (csr_wr) begin
            tx_written_ff[csr_index[ADDR_W-1:0]] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_evt_ff <= s1_evt_in;
      end
      if (s1_move) begin
         out_tx_valid_ff <= s1_evt_ff.tx_valid;
         out_tx_byte_ff  <= out_tx_byte_in;
         out_msg_ff      <= s1_evt_ff.message_ready;
         out_count_ff    <= s1_evt_ff.rx_count;
         out_rx_ff       <= s1_evt_ff.rx_bytes;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_tx_valid      = out_tx_valid_ff;
   assign rsp_tx_byte       = out_tx_byte_ff;
   assign rsp_message_ready = out_msg_ff;
   assign rsp_rx_count      = out_count_ff;
   assign rsp_rx_byte_0     = out_rx_ff[0];
   assign rsp_rx_byte_1     = out_rx_ff[1];
   assign rsp_rx_byte_2     = out_rx_ff[2];
   assign rsp_rx_byte_3     = out_rx_ff[3];
   assign rsp_rx_byte_4     = out_rx_ff[4];

endmodule
